[sv/interval_booking_table_macros.svh]
// ----------------------------------------------------------------------------
// Interval booking table assertion macros
// Shared concurrent assertion forms; the asserting scope supplies clk and
// arst_n.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_BOOKING_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IBT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ibt_pkg.sv]
// ----------------------------------------------------------------------------
// Interval booking table package
// Shared constants, status codes and the cell control types.
// ----------------------------------------------------------------------------
package ibt_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int COUNT_W       = 7;
	localparam int STATUS_W      = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_BOOKED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
	} cell_ctl_t;

	// Handed from each cell to its right-hand neighbor
	typedef struct packed {
		logic occ;
		logic clash;
	} cell_link_t;

endpackage

[sv/ibt_req_if.sv]
// ----------------------------------------------------------------------------
// Booking request channel
// Valid/ready channel carrying one requested interval per transfer.
// ----------------------------------------------------------------------------
interface ibt_req_if import ibt_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] req_start;
	logic [TIME_BITS-1:0] req_end;

	modport source (output valid, output req_start, output req_end, input ready);
	modport sink   (input valid, input req_start, input req_end, output ready);
endinterface

[sv/ibt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Booking response channel
// Valid/ready channel carrying one verdict per booking request.
// ----------------------------------------------------------------------------
interface ibt_rsp_if import ibt_pkg::*;;
	logic                valid;
	logic                ready;
	logic                accepted;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  stored_count;

	modport source (output valid, output accepted, output status, output stored_count,
		input ready);
	modport sink   (input valid, input accepted, input status, input stored_count,
		output ready);
endinterface

[sv/ibt_cell.sv]
// ----------------------------------------------------------------------------
// Interval booking table cell
// Holds one stored interval, checks a broadcast request against it, and
// passes occupancy and the running conflict flag on to its neighbor.
// ----------------------------------------------------------------------------
module ibt_cell import ibt_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] cmp_start,
	input  logic [TIME_BITS-1:0] cmp_end,
	input  logic [TIME_BITS-1:0] ins_start,
	input  logic [TIME_BITS-1:0] ins_end,
	input  cell_link_t           link_in,
	output cell_link_t           link_out
);

	logic                 occ_q;
	logic                 hit_q;
	logic [TIME_BITS-1:0] slot_start_q;
	logic [TIME_BITS-1:0] slot_end_q;
	logic                 fits;
	logic                 take;

	assign fits = ((cmp_start < slot_start_q) && (cmp_end <= slot_start_q)) ||
		((cmp_start >= slot_end_q) && (cmp_end > slot_end_q));

	// First empty cell: left neighbor occupied, this one not
	assign take = ctl.ins_en && link_in.occ && !occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (take) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			hit_q <= !fits;
		end
		if (take) begin
			slot_start_q <= ins_start;
			slot_end_q   <= ins_end;
		end
	end

	assign link_out.occ   = occ_q;
	assign link_out.clash = link_in.clash || (occ_q && hit_q);

endmodule

[sv/interval_booking_table.sv]
// ----------------------------------------------------------------------------
// Interval booking table
// Checks booking requests against all stored intervals and appends the
// ones that do not overlap, while the table has room.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one [req_start, req_end) interval per transfer.
//   rsp (source): one verdict per request: accepted, status (booked,
//   overlap, full) and the number of stored intervals afterwards.
//   A request is checked in every cell of the chain at the edge it is
//   taken; in the decide state the conflict flag has rippled through the
//   chain, and once the output register is free the verdict is loaded
//   into it, with the interval written into the first empty cell.
//   Response valid rises with the verdict load. One request is taken at
//   a time: the decide step must land before the next compare, so a new
//   request is taken only once the block is back in idle.
//   Overlap wins over full: a conflicting request reports overlap.
//   Reset empties the table at once; no clearing pass is needed.
//   If rsp stalls, the finished verdict waits in the output register and
//   one further request is still taken; its verdict waits until the
//   register is free.
// ----------------------------------------------------------------------------
module interval_booking_table import ibt_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ibt_req_if.sink   req,
	ibt_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_DECIDE = 2'b10
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] req_start_q;
	logic [TIME_BITS-1:0] req_end_q;
	logic                 rsp_valid_q;
	logic                 accepted_q;
	status_t              status_q;
	logic [COUNT_W-1:0]   stored_count_q;

	cell_ctl_t            ctl;
	cell_link_t           link [CAPACITY+1];
	logic                 req_xfer;
	logic                 out_free;
	logic                 finish;
	logic                 clash;
	logic                 full;
	logic                 book;
	logic [CNT_W-1:0]     count_next;
	logic [COUNT_W+CNT_W-1:0] count_wide;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == S_DECIDE) && out_free;

	assign clash = link[CAPACITY].clash;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign book  = !clash && !full;

	assign count_next = book ? count_q + CNT_W'(1) : count_q;
	assign count_wide = {{COUNT_W{1'b0}}, count_next};

	assign ctl.cmp_en = req_xfer;
	assign ctl.ins_en = finish && book;

	assign link[0].occ   = 1'b1;
	assign link[0].clash = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ibt_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_start (req.req_start),
			.cmp_end   (req.req_end),
			.ins_start (req_start_q),
			.ins_end   (req_end_q),
			.link_in   (link[i]),
			.link_out  (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (finish) begin
						state_q <= S_IDLE;
						count_q <= count_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_start_q <= req.req_start;
			req_end_q   <= req.req_end;
		end
		if (finish) begin
			accepted_q     <= book;
			status_q       <= clash ? ST_OVERLAP : (full ? ST_FULL : ST_BOOKED);
			stored_count_q <= count_wide[COUNT_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.accepted     = accepted_q;
	assign rsp.status       = status_q;
	assign rsp.stored_count = stored_count_q;

endmodule

[sv/ibt_checker.sv]
// ----------------------------------------------------------------------------
// Interval booking table checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "interval_booking_table_macros.svh"

module ibt_checker import ibt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                accepted,
	input logic [STATUS_W-1:0] status,
	input logic [COUNT_W-1:0]  stored_count
);

	localparam int CAP_W = $clog2(CAPACITY + 1) + COUNT_W;
	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP_W'(CAPACITY));

	`IBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(stored_count), "response changed while stalled")
	`IBT_ASSERT_IMPL(a_acc_status, rsp_valid, accepted == (status == ST_BOOKED), "accepted disagrees with status")
	`IBT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while one is in flight")
	`IBT_ASSERT_IMPL(a_full_count, rsp_valid && (status == ST_FULL), stored_count == CAP_CNT, "full status with table not full")

endmodule

bind interval_booking_table ibt_checker #(
	.CAPACITY (CAPACITY)
) u_ibt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.accepted     (rsp.accepted),
	.status       (rsp.status),
	.stored_count (rsp.stored_count)
);

[bench/interval_booking_table_tb.sv]
// ----------------------------------------------------------------------------
// Interval booking table testbench
// Sends booking requests through the valid/ready request channel and checks
// each verdict against a local booking ledger. A directed opening covers the
// extreme times, adjacent, empty and reversed intervals. A random body of
// fresh, overlapping, adjacent and noise requests then fills the table and
// runs on past full. Both channels idle in phases, and one long response
// hold-off backs the block up.
// ----------------------------------------------------------------------------
module interval_booking_table_tb;
	import ibt_pkg::*;

	localparam int CAPACITY      = CAPACITY_DEF;
	localparam int TB            = TIME_BITS_DEF;
	localparam int RANDOM_ITEMS  = 500;
	localparam int LEDGER        = 0;
	localparam int PLAN          = 1;
	localparam int PHASE_ITEMS   = 60;
	localparam int HOLD_AT_ITEM  = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct packed {
		logic [TB-1:0] t_start;
		logic [TB-1:0] t_stop;
	} booking_t;

	typedef struct packed {
		logic               accepted;
		status_t            status;
		logic [COUNT_W-1:0] stored_count;
	} verdict_t;

	typedef enum int {
		PH_STEADY,
		PH_SENDER_GAPS,
		PH_SINK_STALLS,
		PH_BOTH
	} flow_phase_t;

	logic clk;
	logic arst_n;

	ibt_req_if #(.TIME_BITS(TB)) req_ch ();
	ibt_rsp_if                   rsp_ch ();

	interval_booking_table #(
		.CAPACITY (CAPACITY),
		.TIME_BITS(TB)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Two copies of the table: the ledger follows accepted transfers, the plan
	// follows stimulus generation so random requests can aim at stored slots.
	logic [TB-1:0] tbl_start [2][CAPACITY];
	logic [TB-1:0] tbl_stop  [2][CAPACITY];
	int unsigned   tbl_count [2];

	booking_t    pending_requests[$];
	verdict_t    expected_verdicts[$];
	int unsigned sent_count = 0;
	int unsigned mismatches = 0;
	int unsigned gap_pct;
	int unsigned stall_pct;
	bit          hold_off = 1'b0;

	function automatic bit clashes(int t, logic [TB-1:0] s, logic [TB-1:0] e);
		logic [TB-1:0] xs, xe;
		for (int k = 0; k < tbl_count[t]; k++) begin
			xs = tbl_start[t][k];
			xe = tbl_stop[t][k];
			if (!((s < xs && e <= xs) || (s >= xe && e > xe)))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t book_request(int t, logic [TB-1:0] s, logic [TB-1:0] e);
		verdict_t v;
		v.accepted = 1'b0;
		if (clashes(t, s, e)) begin
			v.status = ST_OVERLAP;
		end else if (tbl_count[t] >= CAPACITY) begin
			v.status = ST_FULL;
		end else begin
			tbl_start[t][tbl_count[t]] = s;
			tbl_stop[t][tbl_count[t]]  = e;
			tbl_count[t]++;
			v.status   = ST_BOOKED;
			v.accepted = 1'b1;
		end
		v.stored_count = COUNT_W'(tbl_count[t]);
		return v;
	endfunction

	function automatic void plan_request(logic [TB-1:0] s, logic [TB-1:0] e);
		booking_t b;
		b.t_start = s;
		b.t_stop  = e;
		void'(book_request(PLAN, s, e));
		pending_requests = {pending_requests, b};
	endfunction

	function automatic void plan_random_request();
		int unsigned   pick, k;
		logic [TB-1:0] s, e, xs, xe, len;
		pick = $urandom_range(99);
		len  = TB'($urandom_range(1, 65536));
		if (pick < 25 || tbl_count[PLAN] == 0) begin
			// fresh interval, retried up to 50 times until it fits the plan
			for (int tries = 0; tries < 50; tries++) begin
				s = $urandom;
				if (s > {TB{1'b1}} - len)
					s = s - len;
				e = s + len;
				if (!clashes(PLAN, s, e))
					break;
			end
		end else begin
			k  = $urandom_range(tbl_count[PLAN] - 1);
			xs = tbl_start[PLAN][k];
			xe = tbl_stop[PLAN][k];
			if (pick < 55) begin
				s = xs + TB'($urandom_range(0, 8)) - TB'(4);
				e = xe + TB'($urandom_range(0, 8)) - TB'(4);
			end else if (pick < 70) begin
				case ($urandom_range(3))
					0: begin s = xs - len; e = xs;       end
					1: begin s = xe;       e = xe + len; end
					2: begin s = xs - len; e = xs + 1;   end
					default: begin s = xe - 1; e = xe + len; end
				endcase
			end else if (pick < 80) begin
				// empty or reversed request near a stored edge
				s = xe + TB'($urandom_range(0, 16));
				e = s - TB'($urandom_range(0, 16));
			end else begin
				s = $urandom;
				e = $urandom;
			end
		end
		plan_request(s, e);
	endfunction

	always_comb begin
		case (flow_phase_t'((sent_count / PHASE_ITEMS) % 4))
			PH_STEADY: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			PH_SENDER_GAPS: begin
				gap_pct   = 75;
				stall_pct = 0;
			end
			PH_SINK_STALLS: begin
				gap_pct   = 0;
				stall_pct = 75;
			end
			default: begin
				gap_pct   = 31;
				stall_pct = 31;
			end
		endcase
	end

	// Request driver: book each transfer into the ledger, then offer the next
	always @(posedge clk or negedge arst_n) begin : req_drive
		bit offer;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_start <= '0;
			req_ch.req_end   <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_verdicts = {expected_verdicts,
					book_request(LEDGER, req_ch.req_start, req_ch.req_end)};
				sent_count <= sent_count + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				offer = pending_requests.size() != 0 &&
					(hold_off || $urandom_range(99) >= gap_pct);
				if (offer) begin
					req_ch.valid     <= 1'b1;
					req_ch.req_start <= pending_requests[0].t_start;
					req_ch.req_end   <= pending_requests[0].t_stop;
					void'(pending_requests.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Verdict monitor
	always @(posedge clk or negedge arst_n) begin : rsp_check
		verdict_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict transfer with no booking request outstanding");
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted,
							rsp_ch.accepted);
						mismatches++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.stored_count !== want.stored_count) begin
						$error("stored_count: expected %0d, got %0d", want.stored_count,
							rsp_ch.stored_count);
						mismatches++;
					end
				end
			end
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Long verdict hold-off while requests keep coming, so the block backs up
	initial begin
		while (sent_count < HOLD_AT_ITEM)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		tbl_count[LEDGER] = 0;
		tbl_count[PLAN]   = 0;

		plan_request(32'h0000_0000, 32'h0000_0010);
		plan_request(32'h0000_0010, 32'h0000_0020);
		plan_request(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		plan_request(32'h0000_000F, 32'h0000_0011);
		plan_request(32'h0000_0000, 32'h0000_0000);
		plan_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		plan_request(32'h0000_1000, 32'h0000_0800);
		plan_request(32'h0000_0900, 32'h0000_0A00);
		plan_request(32'h0000_0020, 32'h0000_0030);
		plan_request(32'h0000_0040, 32'h0000_0040);
		plan_request(32'h0000_003F, 32'h0000_0041);
		plan_request(32'hFFFF_FFFF, 32'h0000_0000);
		plan_request(32'h0000_0000, 32'hFFFF_FFFF);
		plan_request(32'hFFFF_FFEF, 32'hFFFF_FFF0);
		plan_request(32'hFFFF_FFF0, 32'hFFFF_FFF1);
		plan_request(32'h0000_0020, 32'h0000_0021);
		plan_request(32'h0000_001F, 32'h0000_0020);
		plan_request(32'h5555_5555, 32'hAAAA_AAAA);
		plan_request(32'hAAAA_AAAA, 32'h5555_5555);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			plan_random_request();

		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/ibt_pkg.sv
sv/ibt_req_if.sv
sv/ibt_rsp_if.sv
sv/ibt_cell.sv
sv/interval_booking_table.sv
sv/ibt_checker.sv
bench/interval_booking_table_tb.sv
